@@ rtl/core/text_terminal_glyph_renderer_defines.svh @@
// assertion macros for the glyph renderer checker
`ifndef TEXT_TERMINAL_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_TERMINAL_GLYPH_RENDERER_DEFINES_SVH

// checked only out of reset
`define TTGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TTGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/ttgr_pkg.sv @@
// shared codes and constants of the text terminal glyph renderer
package ttgr_pkg;

    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_LOAD  = 2'd0;
    localparam t_cmd CMD_PUT   = 2'd1;
    localparam t_cmd CMD_RESET = 2'd2;

    localparam t_kind KIND_WINDOW = 2'd0;
    localparam t_kind KIND_PIXEL  = 2'd1;
    localparam t_kind KIND_CLEAR  = 2'd2;
    localparam t_kind KIND_START  = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] FIRST_CODE   = 8'd32;

    localparam int CELL_WIDTH  = 6;
    localparam int CELL_HEIGHT = 8;

endpackage

@@ rtl/core/text_terminal_glyph_renderer.sv @@
// text terminal glyph renderer: font memory, cursor state and result sequencer
//
// Input channel (i_valid / o_stall) takes one command per request: load a glyph
// word into the font memory, put a character, or reset the terminal. Output
// channel (o_valid / i_stall) gives display requests, one per cycle at most,
// with o_last on the final request of each command.
// A load gives nothing; the next command may follow at once.
// A drawn character gives a window request once the sequencer advances after
// acceptance, then 48 pixel requests, then a clear and a start line request if it
// wraps into a scrolling newline, one per cycle while the receiver does not stall.
// A newline gives nothing, or a clear and a start line once the screen scrolls;
// a terminal reset gives a full-screen clear and start line 0.
// o_stall is high while the sequencer still has requests of a command to issue;
// the output register decouples the sides, so a new command is taken while the
// last request of the previous one waits.
// The font memory read is registered at acceptance, hidden behind the window request.
// When the receiver stalls, the sequencer holds and the output request stays.
// After reset the cursor sits at the top left, scrolling is off and the start
// line is 0; the font memory keeps no reset value and must be loaded first.
module text_terminal_glyph_renderer #(
    parameter int SCREEN_SIZE = 128,
    parameter int GLYPH_COUNT = 96
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_char_code,
    input  logic [30:0] i_glyph_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_x_first,
    output logic [6:0]  o_y_first,
    output logic [6:0]  o_x_final,
    output logic [6:0]  o_y_final,
    output logic        o_pixel_on,
    output logic [6:0]  o_start_line,
    output logic        o_last
);

    localparam int CW  = $clog2(SCREEN_SIZE);
    localparam int AW  = CW + 1;
    localparam int GAW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    localparam logic [AW-1:0] SCR   = AW'(SCREEN_SIZE);
    localparam logic [AW-1:0] CWID  = AW'(ttgr_pkg::CELL_WIDTH);
    localparam logic [AW-1:0] CHGT  = AW'(ttgr_pkg::CELL_HEIGHT);
    localparam logic [CW-1:0] SMAX  = CW'(SCREEN_SIZE - 1);
    localparam logic [CW-1:0] CLAST = CW'(ttgr_pkg::CELL_HEIGHT - 1);

    localparam logic [1:0] PH_WIN = 2'd0;
    localparam logic [1:0] PH_PIX = 2'd1;
    localparam logic [1:0] PH_CLR = 2'd2;
    localparam logic [1:0] PH_SL  = 2'd3;

    logic [30:0]   r_font [GLYPH_COUNT];
    logic [30:0]   r_rdata;

    logic          r_busy;
    logic [1:0]    r_phase;
    logic          r_tail;
    logic          r_blank;
    logic [2:0]    r_pcol;
    logic [2:0]    r_prow;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          r_scroll;
    logic [CW-1:0] r_fl;

    logic [CW-1:0] r_wx0;
    logic [CW-1:0] r_wy0;
    logic [CW-1:0] r_wx1;
    logic [CW-1:0] r_cy0;
    logic [CW-1:0] r_cy1;

    logic          r_ov;
    logic [1:0]    r_o_kind;
    logic [6:0]    r_o_x0;
    logic [6:0]    r_o_y0;
    logic [6:0]    r_o_x1;
    logic [6:0]    r_o_y1;
    logic          r_o_pix;
    logic [6:0]    r_o_sl;
    logic          r_o_last;

    logic          w_acc;
    logic          w_adv;
    logic [7:0]    w_gofs;
    logic          w_inrange;
    logic [GAW-1:0] w_gidx;

    logic [AW-1:0] w_rowp;
    logic [CW-1:0] nl_row;
    logic          nl_sc;
    logic [AW-1:0] w_flp;
    logic [CW-1:0] nl_fl;

    logic [AW-1:0] w_colp;
    logic          w_wrap;
    logic [AW-1:0] w_x1s;
    logic [CW-1:0] w_x1;

    logic [5:0]    w_mask;
    logic [7:0]    w_col8;
    logic          w_bit;
    logic          w_pend;

    assign w_acc   = i_valid && !o_stall;
    assign w_adv   = r_busy && (!r_ov || !i_stall);
    assign o_stall = r_busy;

    assign w_gofs    = i_char_code - ttgr_pkg::FIRST_CODE;
    assign w_inrange = (i_char_code >= ttgr_pkg::FIRST_CODE) && (w_gofs < 8'(GLYPH_COUNT));
    assign w_gidx    = w_gofs[GAW-1:0];

    // newline applied to the current cursor
    always_comb begin
        w_rowp = AW'(r_row) + CHGT;
        if (w_rowp + CHGT > SCR) begin
            nl_row = '0;
            nl_sc  = 1'b1;
        end else begin
            nl_row = w_rowp[CW-1:0];
            nl_sc  = r_scroll;
        end
        w_flp = AW'(r_fl) + CHGT;
        if (!nl_sc) begin
            nl_fl = r_fl;
        end else if (w_flp >= SCR) begin
            nl_fl = CW'(w_flp - SCR);
        end else begin
            nl_fl = w_flp[CW-1:0];
        end
    end

    always_comb begin
        w_colp = AW'(r_col) + CWID;
        w_wrap = w_colp > AW'(SMAX);
        w_x1s  = w_colp - AW'(1);
        w_x1   = (w_x1s > AW'(SMAX)) ? SMAX : w_x1s[CW-1:0];
    end

    always_comb begin
        unique case (r_pcol)
            3'd0:    w_mask = r_rdata[5:0];
            3'd1:    w_mask = r_rdata[11:6];
            3'd2:    w_mask = r_rdata[17:12];
            3'd3:    w_mask = r_rdata[23:18];
            3'd4:    w_mask = r_rdata[29:24];
            default: w_mask = 6'd0;
        endcase
        w_col8 = r_rdata[30] ? {w_mask, 2'b00} : {2'b00, w_mask};
        w_bit  = w_col8[r_prow] && !r_blank;
        w_pend = (r_prow == 3'd7) && (r_pcol == 3'd5);
    end

    // font memory
    always_ff @(posedge i_clk) begin
        if (w_acc && i_command == ttgr_pkg::CMD_LOAD && w_inrange) begin
            r_font[w_gidx] <= i_glyph_word;
        end
        if (w_acc && i_command == ttgr_pkg::CMD_PUT && w_inrange) begin
            r_rdata <= r_font[w_gidx];
        end
    end

    // cursor state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_WIN;
            r_tail   <= 1'b0;
            r_blank  <= 1'b0;
            r_pcol   <= '0;
            r_prow   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_scroll <= 1'b0;
            r_fl     <= '0;
            r_wx0    <= '0;
            r_wy0    <= '0;
            r_wx1    <= '0;
            r_cy0    <= '0;
            r_cy1    <= '0;
        end else begin
            if (w_acc) begin
                unique case (i_command)
                    ttgr_pkg::CMD_PUT: begin
                        if (i_char_code == ttgr_pkg::NEWLINE_CODE) begin
                            r_col    <= '0;
                            r_row    <= nl_row;
                            r_scroll <= nl_sc;
                            r_fl     <= nl_fl;
                            r_cy0    <= nl_row;
                            r_cy1    <= nl_row + CLAST;
                            r_busy   <= nl_sc;
                            r_phase  <= PH_CLR;
                        end else begin
                            r_wx0   <= r_col;
                            r_wy0   <= r_row;
                            r_wx1   <= w_x1;
                            r_blank <= !w_inrange;
                            r_busy  <= 1'b1;
                            r_phase <= PH_WIN;
                            r_tail  <= w_wrap && nl_sc;
                            if (w_wrap) begin
                                r_col    <= '0;
                                r_row    <= nl_row;
                                r_scroll <= nl_sc;
                                r_fl     <= nl_fl;
                                r_cy0    <= nl_row;
                                r_cy1    <= nl_row + CLAST;
                            end else begin
                                r_col <= w_colp[CW-1:0];
                            end
                        end
                    end
                    ttgr_pkg::CMD_RESET: begin
                        r_col    <= '0;
                        r_row    <= '0;
                        r_scroll <= 1'b0;
                        r_fl     <= '0;
                        r_cy0    <= '0;
                        r_cy1    <= SMAX;
                        r_busy   <= 1'b1;
                        r_phase  <= PH_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_adv) begin
                unique case (r_phase)
                    PH_WIN: begin
                        r_phase <= PH_PIX;
                        r_pcol  <= '0;
                        r_prow  <= '0;
                    end
                    PH_PIX: begin
                        if (w_pend) begin
                            if (r_tail) begin
                                r_phase <= PH_CLR;
                            end else begin
                                r_busy <= 1'b0;
                            end
                        end else if (r_pcol == 3'd5) begin
                            r_pcol <= '0;
                            r_prow <= r_prow + 3'd1;
                        end else begin
                            r_pcol <= r_pcol + 3'd1;
                        end
                    end
                    PH_CLR: begin
                        r_phase <= PH_SL;
                    end
                    PH_SL: begin
                        r_busy <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_x0   <= '0;
            r_o_y0   <= '0;
            r_o_x1   <= '0;
            r_o_y1   <= '0;
            r_o_pix  <= 1'b0;
            r_o_sl   <= '0;
            r_o_last <= 1'b0;
            unique case (r_phase)
                PH_WIN: begin
                    r_o_kind <= ttgr_pkg::KIND_WINDOW;
                    r_o_x0   <= 7'(r_wx0);
                    r_o_y0   <= 7'(r_wy0);
                    r_o_x1   <= 7'(r_wx1);
                    r_o_y1   <= 7'(r_wy0 + CLAST);
                end
                PH_PIX: begin
                    r_o_kind <= ttgr_pkg::KIND_PIXEL;
                    r_o_pix  <= w_bit;
                    r_o_last <= w_pend && !r_tail;
                end
                PH_CLR: begin
                    r_o_kind <= ttgr_pkg::KIND_CLEAR;
                    r_o_y0   <= 7'(r_cy0);
                    r_o_x1   <= 7'(SMAX);
                    r_o_y1   <= 7'(r_cy1);
                end
                PH_SL: begin
                    r_o_kind <= ttgr_pkg::KIND_START;
                    r_o_sl   <= 7'(r_fl);
                    r_o_last <= 1'b1;
                end
                default: begin
                    r_o_kind <= ttgr_pkg::KIND_PIXEL;
                end
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_o_kind;
    assign o_x_first    = r_o_x0;
    assign o_y_first    = r_o_y0;
    assign o_x_final    = r_o_x1;
    assign o_y_final    = r_o_y1;
    assign o_pixel_on   = r_o_pix;
    assign o_start_line = r_o_sl;
    assign o_last       = r_o_last;

endmodule

@@ rtl/core/ttgr_checker.sv @@
// port checker for the text terminal glyph renderer, with its bind
`include "text_terminal_glyph_renderer_defines.svh"

module ttgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_command,
    input logic [7:0]  i_char_code,
    input logic [30:0] i_glyph_word,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [6:0]  o_x_first,
    input logic [6:0]  o_y_first,
    input logic [6:0]  o_x_final,
    input logic [6:0]  o_y_final,
    input logic        o_pixel_on,
    input logic [6:0]  o_start_line,
    input logic        o_last
);

    `TTGR_ASSERT(a_hold, o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_last), "output request dropped or changed under stall")

    `TTGR_ASSERT(a_start_last, o_valid && o_kind == ttgr_pkg::KIND_START |-> o_last, "start line request not last of its command")

    `TTGR_ASSERT(a_window, o_valid && o_kind == ttgr_pkg::KIND_WINDOW |-> !o_last && o_y_final == o_y_first + 7'd7, "bad window request")

    `TTGR_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind text_terminal_glyph_renderer ttgr_checker u_ttgr_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// self-checking bench for the text terminal glyph renderer: directed table, then random text
module tb;

    localparam int SCREEN_SIZE  = 128;
    localparam int GLYPH_COUNT  = 96;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int RESET_CYCLES = 11;

    localparam ttgr_pkg::t_cmd CMD_UNUSED = 2'd3;

    typedef struct packed {
        ttgr_pkg::t_kind kind;
        logic [6:0]      x_first;
        logic [6:0]      y_first;
        logic [6:0]      x_final;
        logic [6:0]      y_final;
        logic            pixel_on;
        logic [6:0]      start_line;
        logic            last;
    } t_display_req;

    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_FULL_CLEAR} t_exp_src;

    typedef struct packed {
        ttgr_pkg::t_cmd cmd;
        logic [7:0]     code;
        logic [30:0]    word;
        t_exp_src       exp_src;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_command;
    logic [7:0]  i_char_code;
    logic [30:0] i_glyph_word;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [6:0]  o_x_first;
    logic [6:0]  o_y_first;
    logic [6:0]  o_x_final;
    logic [6:0]  o_y_final;
    logic        o_pixel_on;
    logic [6:0]  o_start_line;
    logic        o_last;

    text_terminal_glyph_renderer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_glyph_word (i_glyph_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_x_first    (o_x_first),
        .o_y_first    (o_y_first),
        .o_x_final    (o_x_final),
        .o_y_final    (o_y_final),
        .o_pixel_on   (o_pixel_on),
        .o_start_line (o_start_line),
        .o_last       (o_last)
    );

    // terminal state mirrored by the bench
    logic [30:0]  font_mem [GLYPH_COUNT];
    bit           glyph_loaded [GLYPH_COUNT];
    int           cur_col;
    int           cur_row;
    int           start_row;
    bit           scrolling;

    t_display_req step_reqs [$];
    t_display_req pending_reqs [$];
    int           mismatches = 0;
    int           effective_items;
    bit           tx_steady;
    bit           rx_steady = 1'b0;
    int           stall_left = 0;

    t_stim_row directed_rows [22] = '{
        '{ttgr_pkg::CMD_RESET,  8'd0,   31'h0000_0000, EXP_FULL_CLEAR},
        '{ttgr_pkg::CMD_LOAD,   8'd32,  31'h0000_0000, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd127, 31'h7FFF_FFFF, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd33,  31'h3FFF_FFFF, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd34,  31'h5555_5555, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd65,  31'h2AAA_AAAA, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd31,  31'h7FFF_FFFF, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd128, 31'h7FFF_FFFF, EXP_NONE},
        '{ttgr_pkg::CMD_LOAD,   8'd255, 31'h0000_0000, EXP_NONE},
        '{CMD_UNUSED,           8'd65,  31'h7FFF_FFFF, EXP_NONE},
        '{ttgr_pkg::CMD_PUT,    8'd32,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd127, 31'h7FFF_FFFF, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd33,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd34,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd0,   31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd255, 31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd31,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd128, 31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd10,  31'h0000_0000, EXP_NONE},
        '{ttgr_pkg::CMD_PUT,    8'd65,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_PUT,    8'd11,  31'h0000_0000, EXP_MODEL},
        '{ttgr_pkg::CMD_RESET,  8'd255, 31'h7FFF_FFFF, EXP_FULL_CLEAR}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic string req_text(input t_display_req req);
        return $sformatf("kind %0d x %0d..%0d y %0d..%0d pixel %0b start %0d last %0b",
                         req.kind, req.x_first, req.x_final, req.y_first, req.y_final,
                         req.pixel_on, req.start_line, req.last);
    endfunction

    task automatic add_req(input ttgr_pkg::t_kind kind, input int x0, input int y0,
                           input int x1, input int y1, input bit pix, input int sl);
        t_display_req req;
        req.kind       = kind;
        req.x_first    = x0[6:0];
        req.y_first    = y0[6:0];
        req.x_final    = x1[6:0];
        req.y_final    = y1[6:0];
        req.pixel_on   = pix;
        req.start_line = sl[6:0];
        req.last       = 1'b0;
        step_reqs.push_back(req);
    endtask

    task automatic line_feed();
        cur_col = 0;
        cur_row += ttgr_pkg::CELL_HEIGHT;
        if (cur_row + ttgr_pkg::CELL_HEIGHT > SCREEN_SIZE) begin
            scrolling = 1'b1;
            cur_row   = 0;
        end
        if (scrolling) begin
            add_req(ttgr_pkg::KIND_CLEAR, 0, cur_row, SCREEN_SIZE - 1,
                    cur_row + ttgr_pkg::CELL_HEIGHT - 1, 1'b0, 0);
            start_row = (start_row + ttgr_pkg::CELL_HEIGHT) % SCREEN_SIZE;
            add_req(ttgr_pkg::KIND_START, 0, 0, 0, 0, 1'b0, start_row);
        end
    endtask

    // display requests caused by one command, left in step_reqs
    task automatic render_command(input ttgr_pkg::t_cmd cmd, input logic [7:0] code,
                                  input logic [30:0] word);
        int           idx;
        int           x_right;
        int           mask;
        bit           pix;
        logic [30:0]  glyph;
        t_display_req tail;
        step_reqs.delete();
        idx = int'(code) - int'(ttgr_pkg::FIRST_CODE);
        case (cmd)
            ttgr_pkg::CMD_LOAD: begin
                if (idx >= 0 && idx < GLYPH_COUNT) begin
                    font_mem[idx]     = word;
                    glyph_loaded[idx] = 1'b1;
                end
            end
            ttgr_pkg::CMD_PUT: begin
                if (code == ttgr_pkg::NEWLINE_CODE) begin
                    line_feed();
                end else begin
                    glyph   = (idx >= 0 && idx < GLYPH_COUNT) ? font_mem[idx] : '0;
                    x_right = cur_col + ttgr_pkg::CELL_WIDTH - 1;
                    if (x_right > SCREEN_SIZE - 1) x_right = SCREEN_SIZE - 1;
                    add_req(ttgr_pkg::KIND_WINDOW, cur_col, cur_row, x_right,
                            cur_row + ttgr_pkg::CELL_HEIGHT - 1, 1'b0, 0);
                    for (int r = 0; r < ttgr_pkg::CELL_HEIGHT; r++) begin
                        for (int c = 0; c < ttgr_pkg::CELL_WIDTH; c++) begin
                            pix = 1'b0;
                            if (c < ttgr_pkg::CELL_WIDTH - 1) begin
                                mask = int'((glyph >> (6 * c)) & 31'd63);
                                if (glyph[30]) mask = mask << 2;
                                pix = mask[r];
                            end
                            add_req(ttgr_pkg::KIND_PIXEL, 0, 0, 0, 0, pix, 0);
                        end
                    end
                    cur_col += ttgr_pkg::CELL_WIDTH;
                    if (cur_col > SCREEN_SIZE - 1) line_feed();
                end
            end
            ttgr_pkg::CMD_RESET: begin
                cur_col   = 0;
                cur_row   = 0;
                scrolling = 1'b0;
                start_row = 0;
                add_req(ttgr_pkg::KIND_CLEAR, 0, 0, SCREEN_SIZE - 1, SCREEN_SIZE - 1, 1'b0, 0);
                add_req(ttgr_pkg::KIND_START, 0, 0, 0, 0, 1'b0, 0);
            end
            default: ;
        endcase
        if (step_reqs.size() > 0) begin
            tail      = step_reqs.pop_back();
            tail.last = 1'b1;
            step_reqs.push_back(tail);
        end
    endtask

    task automatic send_command(input ttgr_pkg::t_cmd cmd, input logic [7:0] code,
                                input logic [30:0] word, input t_exp_src exp_src);
        int gap;
        gap = tx_steady ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_char_code  <= code;
        i_glyph_word <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        render_command(cmd, code, word);
        case (exp_src)
            EXP_MODEL: begin
                foreach (step_reqs[n]) pending_reqs.push_back(step_reqs[n]);
            end
            EXP_FULL_CLEAR: begin
                pending_reqs.push_back(t_display_req'{ttgr_pkg::KIND_CLEAR, 7'd0, 7'd0,
                                                      7'd127, 7'd127, 1'b0, 7'd0, 1'b0});
                pending_reqs.push_back(t_display_req'{ttgr_pkg::KIND_START, 7'd0, 7'd0,
                                                      7'd0, 7'd0, 1'b0, 7'd0, 1'b1});
            end
            default: ;
        endcase
        if (cmd == ttgr_pkg::CMD_PUT || cmd == ttgr_pkg::CMD_RESET ||
            (cmd == ttgr_pkg::CMD_LOAD && code >= ttgr_pkg::FIRST_CODE &&
             code < ttgr_pkg::FIRST_CODE + GLYPH_COUNT))
            effective_items++;
    endtask

    always @(posedge i_clk) begin : request_sink
        t_display_req got;
        t_display_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_kind, o_x_first, o_y_first, o_x_final, o_y_final, o_pixel_on,
                   o_start_line, o_last};
            if (pending_reqs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected request %s", $realtime, req_text(got));
            end else begin
                want = pending_reqs.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected %s", $realtime, req_text(want));
                        $display("%0t:      got %s", $realtime, req_text(got));
                    end
                end
            end
        end
        if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
        if (stall_left == 0 && !rx_steady) stall_left = idle_cycles();
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    initial begin : stimulus
        int          line_len;
        int          idx;
        int          r;
        logic [7:0]  code;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= ttgr_pkg::CMD_LOAD;
        i_char_code  <= '0;
        i_glyph_word <= '0;
        cur_col      = 0;
        cur_row      = 0;
        start_row    = 0;
        scrolling    = 1'b0;
        tx_steady    = 1'b0;
        foreach (glyph_loaded[n]) glyph_loaded[n] = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_command(directed_rows[n].cmd, directed_rows[n].code, directed_rows[n].word,
                         directed_rows[n].exp_src);

        // random text: mostly lines ending in newline, some long enough to wrap
        effective_items = 0;
        while (effective_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                code = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(32, 127));
                send_command(ttgr_pkg::CMD_LOAD, code, 31'($urandom), EXP_MODEL);
            end else if (r < 14) begin
                send_command(ttgr_pkg::CMD_RESET, 8'($urandom), 31'($urandom), EXP_MODEL);
            end else if (r < 17) begin
                send_command(CMD_UNUSED, 8'($urandom), 31'($urandom), EXP_MODEL);
            end else begin
                line_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8)
                                                      : $urandom_range(18, 30);
                repeat (line_len) begin
                    if ($urandom_range(0, 14) == 0) begin
                        do code = 8'($urandom_range(0, 255));
                        while ((code >= ttgr_pkg::FIRST_CODE &&
                                code < ttgr_pkg::FIRST_CODE + GLYPH_COUNT) ||
                               code == ttgr_pkg::NEWLINE_CODE);
                    end else begin
                        do idx = $urandom_range(0, GLYPH_COUNT - 1);
                        while (!glyph_loaded[idx]);
                        code = 8'(idx + ttgr_pkg::FIRST_CODE);
                    end
                    send_command(ttgr_pkg::CMD_PUT, code, 31'($urandom), EXP_MODEL);
                end
                if ($urandom_range(0, 4) != 0)
                    send_command(ttgr_pkg::CMD_PUT, ttgr_pkg::NEWLINE_CODE, 31'($urandom),
                                 EXP_MODEL);
            end
        end
        i_valid <= 1'b0;

        while (pending_reqs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_reqs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ text_terminal_glyph_renderer.f @@
+incdir+rtl/core
rtl/core/ttgr_pkg.sv
rtl/core/text_terminal_glyph_renderer.sv
rtl/core/ttgr_checker.sv
test/tb.sv
